@@ design/facr_pkg.sv @@
package facr_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int AGE_W     = 32;
  localparam int WAY_OUT_W = 4;
  localparam int LOFF_W    = 4;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int OUT_DW    = 104;

  localparam logic [0:0] REG_POLICY = 1'b0;
  localparam logic [0:0] REG_LOFF   = 1'b1;

  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_PLRU = 1'b1;

  localparam logic [LOFF_W-1:0] LOFF_RST = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // search token flags, handed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
    logic inv;
  } scan_t;

  // update broadcast to every cell at commit
  typedef struct packed {
    logic en;
    logic fill;
    logic age_en;
  } upd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ design/facr_cell.sv @@
module facr_cell #(
  parameter int WAY_W = 4,
  parameter int TAG_W = 32,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  facr_pkg::scan_t             scan_i,
  input  logic [TAG_W-1:0]            blk_i,
  input  logic [WAY_W-1:0]            hway_i,
  input  logic [WAY_W-1:0]            iway_i,
  input  logic [WAY_W-1:0]            mway_i,
  input  logic [facr_pkg::AGE_W-1:0]  mage_i,
  output facr_pkg::scan_t             scan_o,
  output logic [TAG_W-1:0]            blk_o,
  output logic [WAY_W-1:0]            hway_o,
  output logic [WAY_W-1:0]            iway_o,
  output logic [WAY_W-1:0]            mway_o,
  output logic [facr_pkg::AGE_W-1:0]  mage_o,
  input  facr_pkg::upd_t              upd_i,
  input  logic [WAY_W-1:0]            upd_way_i,
  input  logic [TAG_W-1:0]            upd_blk_i
);

  localparam logic [WAY_W-1:0] ME = WAY_W'(IDX);

  logic                       valid_r, valid_nxt;
  logic [TAG_W-1:0]           tag_r, tag_nxt;
  logic [facr_pkg::AGE_W-1:0] age_r, age_nxt;

  facr_pkg::scan_t            scan_r, scan_nxt;
  logic [TAG_W-1:0]           blk_r;
  logic [WAY_W-1:0]           hway_r, hway_nxt;
  logic [WAY_W-1:0]           iway_r, iway_nxt;
  logic [WAY_W-1:0]           mway_r, mway_nxt;
  logic [facr_pkg::AGE_W-1:0] mage_r, mage_nxt;

  logic hit_here, inv_here, older;

  assign hit_here = valid_r && (tag_r == blk_i);
  assign inv_here = !valid_r;
  assign older    = age_r > mage_i;

  always_comb begin
    scan_nxt.vld = scan_i.vld;
    scan_nxt.hit = scan_i.hit | hit_here;
    scan_nxt.inv = scan_i.inv | inv_here;
    hway_nxt     = (!scan_i.hit && hit_here) ? ME : hway_i;
    iway_nxt     = (!scan_i.inv && inv_here) ? ME : iway_i;
    mway_nxt     = older ? ME : mway_i;
    mage_nxt     = older ? age_r : mage_i;
  end

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    age_nxt   = age_r;
    if (upd_i.en) begin
      if (upd_way_i == ME) begin
        if (upd_i.fill) begin
          valid_nxt = 1'b1;
          tag_nxt   = upd_blk_i;
        end
        if (upd_i.age_en) begin
          age_nxt = '0;
        end
      end else if (upd_i.age_en) begin
        age_nxt = facr_pkg::sat_inc(age_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      scan_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    blk_r  <= blk_i;
    hway_r <= hway_nxt;
    iway_r <= iway_nxt;
    mway_r <= mway_nxt;
    mage_r <= mage_nxt;
  end

  assign scan_o = scan_r;
  assign blk_o  = blk_r;
  assign hway_o = hway_r;
  assign iway_o = iway_r;
  assign mway_o = mway_r;
  assign mage_o = mage_r;

endmodule

@@ design/facr_plru.sv @@
module facr_plru #(
  parameter int WAYS  = 16,
  parameter int WAY_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             touch_en,
  input  logic [WAY_W-1:0] touch_way,
  output logic [WAY_W-1:0] victim
);

  localparam int NODES = 1 << WAY_W;
  localparam logic [WAY_W-1:0] LAST = WAY_W'(WAYS - 1);

  logic [NODES-1:1] tree_r, tree_nxt;
  logic [WAY_W-1:0] vnode, vway, tnode;
  logic             vb;

  // walk: a clear node bit leads right
  always_comb begin
    vnode = WAY_W'(1);
    vway  = '0;
    vb    = 1'b0;
    for (int l = 0; l < WAY_W; l++) begin
      vb    = ~tree_r[vnode];
      vway  = WAY_W'({vway, vb});
      vnode = WAY_W'({vnode, vb});
    end
    victim = (vway > LAST) ? LAST : vway;
  end

  always_comb begin
    tree_nxt = tree_r;
    tnode    = WAY_W'(1);
    if (touch_en) begin
      for (int l = WAY_W - 1; l >= 0; l--) begin
        tree_nxt[tnode] = touch_way[l];
        tnode           = WAY_W'({tnode, touch_way[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_r <= '0;
    end else begin
      tree_r <= tree_nxt;
    end
  end

endmodule

@@ design/fully_associative_cache_replacement_unit.sv @@
// channel | dir  | signals                          | beat
// in      | sink | in_tvalid/in_tready/in_tdata     | one access address
// out     | src  | out_tvalid/out_tready/out_tdata  | hit flag, way, running totals
// cfg     | sink | cfg_psel..cfg_pready (APB)       | policy, line offset
//
// From accept, the search token walks the row of way cells one cell per cycle, then
// its result is latched and the commit state updates the cells and loads out.
// One item is in flight; the next is taken while a result waits on out.
// Reset clears valid bits, ages, tree bits, totals and config; tags need no clear.
// A stalled out holds its beat; a finished search waits in commit until out frees.
module fully_associative_cache_replacement_unit #(
  parameter int WAYS         = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [facr_pkg::ADDR_W-1:0]   in_tdata,    // [31:0] address
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [facr_pkg::OUT_DW-1:0]   out_tdata,   // way, hit_count, miss_count,
                                                     // access_count, pad
  output logic                          out_tuser,   // hit
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [facr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [facr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [facr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int WAY_W = $clog2(WAYS);
  localparam int TAG_W = (ADDRESS_BITS < facr_pkg::ADDR_W) ? ADDRESS_BITS : facr_pkg::ADDR_W;
  localparam int OW    = facr_pkg::WAY_OUT_W;
  localparam int CW    = facr_pkg::CNT_W;

  facr_pkg::state_t state_r, state_nxt;

  logic                        policy_r;
  logic [facr_pkg::LOFF_W-1:0] loff_r;
  logic                        cfg_wr;
  logic [0:0]                  cfg_idx;

  logic in_fire, chain_done, commit_go;

  facr_pkg::scan_t             scan_c [0:WAYS];
  logic [TAG_W-1:0]            blk_c  [0:WAYS];
  logic [WAY_W-1:0]            hway_c [0:WAYS];
  logic [WAY_W-1:0]            iway_c [0:WAYS];
  logic [WAY_W-1:0]            mway_c [0:WAYS];
  logic [facr_pkg::AGE_W-1:0]  mage_c [0:WAYS];
  logic [WAYS-1:0]             chain_vld;

  logic                        hit_r, inv_r;
  logic [WAY_W-1:0]            hway_r, iway_r, mway_r;
  logic [TAG_W-1:0]            blk_r;

  logic [WAY_W-1:0]            victim, used;
  logic [WAY_W+OW-1:0]         used_ext;
  facr_pkg::upd_t              upd;

  logic [CW-1:0]               hits_r, misses_r, accs_r;
  logic [OW-1:0]               way_out_r;
  logic                        hit_out_r, out_vld_r, out_vld_nxt;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_comb begin
    unique case (cfg_idx)
      facr_pkg::REG_POLICY: cfg_prdata = {{(facr_pkg::CFG_DW-1){1'b0}}, policy_r};
      facr_pkg::REG_LOFF:   cfg_prdata = {{(facr_pkg::CFG_DW-facr_pkg::LOFF_W){1'b0}}, loff_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= facr_pkg::POL_LRU;
      loff_r   <= facr_pkg::LOFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        facr_pkg::REG_POLICY: policy_r <= cfg_pwdata[0];
        facr_pkg::REG_LOFF:   loff_r   <= cfg_pwdata[facr_pkg::LOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      facr_pkg::ST_IDLE:   if (in_tvalid) state_nxt = facr_pkg::ST_SCAN;
      facr_pkg::ST_SCAN:   if (chain_done) state_nxt = facr_pkg::ST_COMMIT;
      facr_pkg::ST_COMMIT: if (!out_vld_r || out_tready) state_nxt = facr_pkg::ST_IDLE;
      default:             state_nxt = facr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    commit_go = 1'b0;
    unique case (state_r)
      facr_pkg::ST_IDLE:   in_tready = 1'b1;
      facr_pkg::ST_SCAN:   ;
      facr_pkg::ST_COMMIT: commit_go = !out_vld_r || out_tready;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= facr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_fire    = in_tvalid && in_tready;
  assign chain_done = scan_c[WAYS].vld;

  // head of the row
  always_comb begin
    scan_c[0].vld = in_fire;
    scan_c[0].hit = 1'b0;
    scan_c[0].inv = 1'b0;
    blk_c[0]      = in_tdata[TAG_W-1:0] >> loff_r;
    hway_c[0]     = '0;
    iway_c[0]     = '0;
    mway_c[0]     = '0;
    mage_c[0]     = '0;
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    facr_cell #(
      .WAY_W (WAY_W),
      .TAG_W (TAG_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .scan_i    (scan_c[g]),
      .blk_i     (blk_c[g]),
      .hway_i    (hway_c[g]),
      .iway_i    (iway_c[g]),
      .mway_i    (mway_c[g]),
      .mage_i    (mage_c[g]),
      .scan_o    (scan_c[g+1]),
      .blk_o     (blk_c[g+1]),
      .hway_o    (hway_c[g+1]),
      .iway_o    (iway_c[g+1]),
      .mway_o    (mway_c[g+1]),
      .mage_o    (mage_c[g+1]),
      .upd_i     (upd),
      .upd_way_i (used),
      .upd_blk_i (blk_r)
    );
    assign chain_vld[g] = scan_c[g+1].vld;
  end

  always_ff @(posedge clk) begin
    if (state_r == facr_pkg::ST_SCAN && chain_done) begin
      hit_r  <= scan_c[WAYS].hit;
      inv_r  <= scan_c[WAYS].inv;
      hway_r <= hway_c[WAYS];
      iway_r <= iway_c[WAYS];
      mway_r <= mway_c[WAYS];
      blk_r  <= blk_c[WAYS];
    end
  end

  facr_plru #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_plru (
    .clk       (clk),
    .rst_n     (rst_n),
    .touch_en  (commit_go && (policy_r == facr_pkg::POL_PLRU)),
    .touch_way (used),
    .victim    (victim)
  );

  always_comb begin
    if (hit_r) begin
      used = hway_r;
    end else if (policy_r == facr_pkg::POL_PLRU) begin
      used = victim;
    end else begin
      used = inv_r ? iway_r : mway_r;
    end
    used_ext   = {{OW{1'b0}}, used};
    upd.en     = commit_go;
    upd.fill   = !hit_r;
    upd.age_en = (policy_r == facr_pkg::POL_LRU);
  end

  // totals double as the result payload; they only move at commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      accs_r   <= '0;
    end else if (commit_go) begin
      accs_r <= facr_pkg::sat_inc(accs_r);
      if (hit_r) begin
        hits_r <= facr_pkg::sat_inc(hits_r);
      end else begin
        misses_r <= facr_pkg::sat_inc(misses_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      way_out_r <= used_ext[OW-1:0];
      hit_out_r <= hit_r;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (commit_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = hit_out_r;
  assign out_tdata  = {{(facr_pkg::OUT_DW-OW-3*CW){1'b0}}, accs_r, misses_r, hits_r,
                       way_out_r};

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one search token in the row");

  a_token_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##(WAYS) chain_done)
    else $error("search token did not reach the end of the row in time");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> (out_tvalid && (out_tuser == $past(hit_r))))
    else $error("commit did not present its beat");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == facr_pkg::ST_COMMIT))
    else $error("result beat raised outside commit");
`endif

endmodule
